// ===== src/ecd_pkg.sv =====
// types and constants shared by the ema crossover detector
// no dependencies; imported by ema_crossover_detector and the testbench
`default_nettype none

package ecd_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned AlphaW = 17;

  localparam logic [AlphaW-1:0] AlphaLongRst  = 17'd6242;
  localparam logic [AlphaW-1:0] AlphaShortRst = 17'd23831;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_ALPHA_LONG  = 1'b0,
    CFG_ALPHA_SHORT = 1'b1
  } cfg_index_t;

  // where the short average sits against the long one
  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_BELOW = 2'd1,
    REL_ABOVE = 2'd2
  } relation_t;

  // crossover code carried with each result
  typedef enum logic [1:0] {
    SIG_NONE    = 2'd0,
    SIG_BEARISH = 2'd1,
    SIG_BULLISH = 2'd2
  } signal_t;

endpackage

`default_nettype wire

// ===== src/ema_crossover_detector.sv =====
// ema crossover detector: two exponential moving averages and a crossover flag
// depends on ecd_pkg (widths, register indexes, relation and signal codes)
`default_nettype none

// Price samples (unsigned Q16.16) come in on the in_ stream, one per transaction,
// and every sample gives exactly one result transaction on the out_ stream. After
// reset or a sample flagged with restart, the first SEED_LENGTH - 1 samples only build
// up the seed: their results carry zero averages and ready_res = 0. The sample that
// completes the seed loads both averages with the truncated mean of the seed
// samples. Each later sample moves each average by floor(alpha * (x - ema) / 2^16),
// clamped to the price range, and reports a bullish crossover when the short
// average rises above the long one from strictly below, bearish for the mirror
// case. The block takes one sample every clock cycle while out_tready does not stall
// it; a sample passes the input register, then the result register. The cycle
// is set by the single update stage: two 33x18 signed multiplies for the averages
// in parallel with a 32x33 reciprocal multiply that divides each seed sample by
// SEED_LENGTH into a running quotient and remainder. in_tready follows out_tready
// combinationally. The smoothing factors are written on the cfg_ port, which is
// always ready; write them only while no sample is in flight.

module ema_crossover_detector
  import ecd_pkg::*;
#(
  parameter int unsigned SEED_LENGTH = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [PriceW-1:0]   in_tdata,   // [31:0] close_price
  input  wire logic                in_tuser,   // [0] restart
  // result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [2*PriceW-1:0]      out_tdata,  // [31:0] long_average, [63:32] short_average
  output logic [2:0]               out_tuser,  // [0] ready_res, [2:1] signal
  // configuration writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [AlphaW-1:0]   cfg_data
);

  localparam int unsigned CntW = $clog2(SEED_LENGTH + 1);
  localparam logic [CntW-1:0] SeedLen = CntW'(SEED_LENGTH);
  // floor(2^32 / SEED_LENGTH); estimate is exact or one short
  localparam logic [PriceW:0] SeedRecip = 33'((64'd1 << PriceW) / SEED_LENGTH);

  // one step of an average, floor shift of the signed product, clamped
  function automatic logic [PriceW-1:0] ema_step(input logic [PriceW-1:0] ema,
                                                 input logic [PriceW-1:0] x,
                                                 input logic [AlphaW-1:0] alpha);
    logic signed [PriceW:0]   diff;
    logic signed [50:0]       prod;
    logic signed [34:0]       delta;
    logic signed [35:0]       sum;
    logic [PriceW-1:0]        res;
    diff  = $signed({1'b0, x}) - $signed({1'b0, ema});
    prod  = diff * $signed({1'b0, alpha});
    delta = prod[50:16];
    sum   = $signed({4'b0000, ema}) + $signed({delta[34], delta});
    if (sum[35]) begin
      res = '0;
    end else if (sum[34:32] != 3'b000) begin
      res = '1;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

  function automatic logic [64:0] x_ext(input logic [PriceW-1:0] v);
    return {33'b0, v};
  endfunction

  // configuration registers
  logic [AlphaW-1:0] alpha_long_r;
  logic [AlphaW-1:0] alpha_short_r;

  // input register
  logic              in_valid_r;
  logic [PriceW-1:0] in_x_r;
  logic              in_restart_r;

  // block state
  logic [PriceW-1:0] long_ema_r,  long_ema_nxt;
  logic [PriceW-1:0] short_ema_r, short_ema_nxt;
  logic [PriceW-1:0] seed_quo_r,  seed_quo_nxt;   // running sum div SEED_LENGTH
  logic [CntW-1:0]   seed_rem_r,  seed_rem_nxt;   // running sum mod SEED_LENGTH
  logic [CntW-1:0]   seed_cnt_r,  seed_cnt_nxt;
  relation_t         last_rel_r,  last_rel_nxt;

  // result register
  logic              out_valid_r;
  logic [PriceW-1:0] out_long_r,  out_long_nxt;
  logic [PriceW-1:0] out_short_r, out_short_nxt;
  logic              out_ready_res_r, out_ready_res_nxt;
  signal_t           out_signal_r, out_signal_nxt;

  logic              advance;

  // seed divide path
  logic [64:0]       recip_prod;
  logic [PriceW-1:0] quo_est;
  logic [PriceW+CntW-1:0] back_prod;
  logic [PriceW+CntW-1:0] rem_wide;
  logic [CntW:0]     rem_est;
  logic [PriceW-1:0] x_quo;
  logic [CntW-1:0]   x_rem;
  logic [CntW:0]     rem_sum;
  logic              rem_carry;

  logic [CntW-1:0]   cnt_eff;
  logic [PriceW-1:0] quo_eff;
  logic [CntW-1:0]   rem_eff;
  logic              seeding;
  logic [PriceW-1:0] long_upd;
  logic [PriceW-1:0] short_upd;
  relation_t         rel_upd;

  // the update stage fires when a sample waits and the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // x / SEED_LENGTH by reciprocal, then one correction step
  assign recip_prod = x_ext(in_x_r) * {32'b0, SeedRecip};
  assign quo_est    = recip_prod[63:32];
  assign back_prod  = (PriceW + CntW)'(quo_est) * (PriceW + CntW)'(SeedLen);
  assign rem_wide   = (PriceW + CntW)'(in_x_r) - back_prod;
  assign rem_est    = rem_wide[CntW:0];

  always_comb begin
    if (rem_est >= {1'b0, SeedLen}) begin
      x_quo = quo_est + 32'd1;
      x_rem = CntW'(rem_est - {1'b0, SeedLen});
    end else begin
      x_quo = quo_est;
      x_rem = rem_est[CntW-1:0];
    end
  end

  // restart wipes the seed before this sample joins it
  assign cnt_eff = in_restart_r ? '0 : seed_cnt_r;
  assign quo_eff = in_restart_r ? '0 : seed_quo_r;
  assign rem_eff = in_restart_r ? '0 : seed_rem_r;
  assign seeding = (cnt_eff < SeedLen);

  assign rem_sum   = {1'b0, rem_eff} + {1'b0, x_rem};
  assign rem_carry = (rem_sum >= {1'b0, SeedLen});

  // both averages move in parallel
  assign long_upd  = ema_step(long_ema_r,  in_x_r, alpha_long_r);
  assign short_upd = ema_step(short_ema_r, in_x_r, alpha_short_r);

  always_comb begin
    if (short_upd > long_upd) begin
      rel_upd = REL_ABOVE;
    end else if (short_upd < long_upd) begin
      rel_upd = REL_BELOW;
    end else begin
      rel_upd = REL_EQUAL;
    end
  end

  always_comb begin
    long_ema_nxt   = long_ema_r;
    short_ema_nxt  = short_ema_r;
    seed_quo_nxt   = quo_eff;
    seed_rem_nxt   = rem_eff;
    seed_cnt_nxt   = cnt_eff;
    last_rel_nxt   = in_restart_r ? REL_EQUAL : last_rel_r;
    out_signal_nxt = SIG_NONE;
    if (in_restart_r) begin
      long_ema_nxt  = '0;
      short_ema_nxt = '0;
    end
    if (seeding) begin
      seed_quo_nxt = quo_eff + x_quo + PriceW'(rem_carry);
      seed_rem_nxt = rem_carry ? CntW'(rem_sum - {1'b0, SeedLen}) : rem_sum[CntW-1:0];
      seed_cnt_nxt = cnt_eff + CntW'(1);
      if (seed_cnt_nxt == SeedLen) begin
        // seed complete: both averages start at the mean
        long_ema_nxt  = seed_quo_nxt;
        short_ema_nxt = seed_quo_nxt;
        last_rel_nxt  = REL_EQUAL;
      end
    end else begin
      long_ema_nxt  = long_upd;
      short_ema_nxt = short_upd;
      last_rel_nxt  = rel_upd;
      if (rel_upd == REL_ABOVE && last_rel_r == REL_BELOW) begin
        out_signal_nxt = SIG_BULLISH;
      end else if (rel_upd == REL_BELOW && last_rel_r == REL_ABOVE) begin
        out_signal_nxt = SIG_BEARISH;
      end
    end
    out_ready_res_nxt = (seed_cnt_nxt == SeedLen);
    out_long_nxt      = out_ready_res_nxt ? long_ema_nxt  : '0;
    out_short_nxt     = out_ready_res_nxt ? short_ema_nxt : '0;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_long_r  <= AlphaLongRst;
      alpha_short_r <= AlphaShortRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_ALPHA_LONG:  alpha_long_r  <= cfg_data;
        CFG_ALPHA_SHORT: alpha_short_r <= cfg_data;
        default:         alpha_long_r  <= alpha_long_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_x_r       <= in_tdata;
      in_restart_r <= in_tuser;
    end
  end

  // averages and seed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ema_r  <= '0;
      short_ema_r <= '0;
      seed_quo_r  <= '0;
      seed_rem_r  <= '0;
      seed_cnt_r  <= '0;
      last_rel_r  <= REL_EQUAL;
    end else if (advance) begin
      long_ema_r  <= long_ema_nxt;
      short_ema_r <= short_ema_nxt;
      seed_quo_r  <= seed_quo_nxt;
      seed_rem_r  <= seed_rem_nxt;
      seed_cnt_r  <= seed_cnt_nxt;
      last_rel_r  <= last_rel_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_long_r      <= out_long_nxt;
      out_short_r     <= out_short_nxt;
      out_ready_res_r <= out_ready_res_nxt;
      out_signal_r    <= out_signal_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_short_r, out_long_r};
  assign out_tuser  = {out_signal_r, out_ready_res_r};

`ifndef SYNTHESIS
  // seed count saturates at the seed length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seed_cnt_r <= SeedLen)
    else $error("seed count past seed length");

  // running remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seed_rem_r < SeedLen)
    else $error("seed remainder out of range");

  // unseeded results carry zero averages and no crossover
  a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready_res_r |->
      out_long_r == '0 && out_short_r == '0 && out_signal_r == SIG_NONE)
    else $error("unseeded result not cleared");

  // a bullish crossover has short above long in the same result
  a_bull_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_signal_r == SIG_BULLISH |-> out_short_r > out_long_r)
    else $error("bullish signal with short not above long");

  // a bearish crossover has short below long in the same result
  a_bear_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_signal_r == SIG_BEARISH |-> out_short_r < out_long_r)
    else $error("bearish signal with short not below long");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for ema_crossover_detector: directed and random price streams
// depends on ecd_pkg and ema_crossover_detector; keeps its own model of both averages
`timescale 1ns / 1ps

module testbench;
  import ecd_pkg::*;

  localparam int unsigned SeedLen    = 5;
  localparam int unsigned HoldCycles = 300;     // long receiver hold-off
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned CycleLimit = 500000;

  // one result transaction as the model predicts it
  typedef struct packed {
    logic [PriceW-1:0] long_avg;
    logic [PriceW-1:0] short_avg;
    logic              seeded;
    signal_t           crossover;
  } ema_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PriceW-1:0]     in_tdata = '0;    // [31:0] close_price
  logic                  in_tuser = 1'b0;  // [0] restart
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*PriceW-1:0]   out_tdata;        // [31:0] long_average, [63:32] short_average
  logic [2:0]            out_tuser;        // [0] ready_res, [2:1] signal
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = CFG_ALPHA_LONG;
  logic [AlphaW-1:0]     cfg_data = '0;

  // model state, mirrors what the block keeps
  logic [AlphaW-1:0] alpha_l;
  logic [AlphaW-1:0] alpha_s;
  logic [PriceW-1:0] avg_long;
  logic [PriceW-1:0] avg_short;
  logic [34:0]       seed_total;
  logic [2:0]        seed_taken;
  relation_t         prev_rel;

  ema_result_t awaited_results[$];

  int  errors = 0;
  int  cycle_count = 0;
  int  phase_number = 0;
  bit  quiet = 1'b0;          // no idling on either side
  bit  hold_request = 1'b0;   // asks the receiver for one long hold-off

  always #4 clk = ~clk;

  ema_crossover_detector #(
    .SEED_LENGTH(SeedLen)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // one average update: floor of alpha * (x - ema) / 2^16, clamped to the price range
  function automatic logic [PriceW-1:0] track_average(input logic [PriceW-1:0] avg,
                                                      input logic [PriceW-1:0] price,
                                                      input logic [AlphaW-1:0] alpha);
    longint diff;
    longint delta;
    longint next_avg;
    diff = longint'(price) - longint'(avg);
    if (diff >= 0) begin
      delta = (longint'(alpha) * diff) >>> 16;
    end else begin
      // rounding up the magnitude gives the floor of a negative step
      delta = -((longint'(alpha) * -diff + 65535) >>> 16);
    end
    next_avg = longint'(avg) + delta;
    if (next_avg < 0) next_avg = 0;
    if (next_avg > 64'h0000_0000_FFFF_FFFF) next_avg = 64'h0000_0000_FFFF_FFFF;
    return next_avg[PriceW-1:0];
  endfunction

  // advances the model by one accepted sample and returns the result it must give
  function automatic ema_result_t next_crossover_result(input logic [PriceW-1:0] price,
                                                        input logic restart);
    ema_result_t res;
    relation_t   rel;
    logic [34:0] mean;
    res.crossover = SIG_NONE;
    if (restart) begin
      avg_long   = '0;
      avg_short  = '0;
      seed_total = '0;
      seed_taken = '0;
      prev_rel   = REL_EQUAL;
    end
    if (seed_taken < SeedLen) begin
      seed_total = seed_total + 35'(price);
      seed_taken = seed_taken + 3'd1;
      if (seed_taken == SeedLen) begin
        mean = seed_total / 35'(SeedLen);
        if (mean[34:32] != 3'd0) mean = 35'h0_FFFF_FFFF;
        avg_long  = mean[PriceW-1:0];
        avg_short = mean[PriceW-1:0];
        prev_rel  = REL_EQUAL;
      end
    end else begin
      avg_long  = track_average(avg_long, price, alpha_l);
      avg_short = track_average(avg_short, price, alpha_s);
      if (avg_short > avg_long) rel = REL_ABOVE;
      else if (avg_short < avg_long) rel = REL_BELOW;
      else rel = REL_EQUAL;
      // an equal relation in between breaks a crossover
      if (rel == REL_ABOVE && prev_rel == REL_BELOW) res.crossover = SIG_BULLISH;
      else if (rel == REL_BELOW && prev_rel == REL_ABOVE) res.crossover = SIG_BEARISH;
      prev_rel = rel;
    end
    res.seeded    = (seed_taken == SeedLen);
    res.long_avg  = res.seeded ? avg_long : '0;
    res.short_avg = res.seeded ? avg_short : '0;
    return res;
  endfunction

  // offers one sample and waits for its transaction; valid stays high for the next one
  task automatic send_sample(input logic [PriceW-1:0] price, input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_results.push_back(next_crossover_result(price, restart));
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // waits until every predicted result has come out, then idles for DrainWait
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // writes both smoothing factors once the block is idle
  task automatic write_alphas(input logic [AlphaW-1:0] long_val,
                              input logic [AlphaW-1:0] short_val);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ALPHA_LONG;
    cfg_data  <= long_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    alpha_l = long_val;
    cfg_index <= CFG_ALPHA_SHORT;
    cfg_data  <= short_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    alpha_s = short_val;
    cfg_valid <= 1'b0;
  endtask

  // seeding from reset, restart in the middle of a seed and after it, reset factors
  task automatic test_restart();
    send_sample(32'd301, 1'b0);
    send_sample(32'd402, 1'b1);
    send_sample(32'd503, 1'b0);
    send_sample(32'd604, 1'b1);
    send_sample(32'd705, 1'b0);
    send_sample(32'd806, 1'b0);
    send_sample(32'd907, 1'b0);
    send_sample(32'd1008, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'd5, 1'b1);
  endtask

  // full-scale seed, then overshooting factors pinned at both ends of the range
  task automatic test_price_extremes();
    write_alphas(17'h1FFFF, 17'h10000);
    send_sample(32'hFFFF_FFFF, 1'b1);
    repeat (SeedLen - 1) send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
  endtask

  // long average frozen, short follows the price: each relation set by hand
  task automatic test_crossovers();
    logic [PriceW-1:0] mid;
    mid = 32'h8000_0000;
    write_alphas(17'h00000, 17'h10000);
    send_sample(mid, 1'b1);
    repeat (SeedLen - 1) send_sample(mid, 1'b0);
    send_sample(mid - 32'd1, 1'b0);   // below, nothing yet
    send_sample(mid + 32'd1, 1'b0);   // bullish
    send_sample(mid - 32'd1, 1'b0);   // bearish
    send_sample(mid, 1'b0);           // equal
    send_sample(mid + 32'd1, 1'b0);   // above after equal, no crossover
    send_sample(mid - 32'd1, 1'b0);   // bearish
  endtask

  // receiver holds off for a long stretch while samples keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_sample(32'h0100_0000, 1'b1);
    repeat (79) send_sample(32'h0100_0000 + $urandom_range(0, 32'h0010_0000), 1'b0);
  endtask

  // random windows of random-walk prices under a factor pair chosen per phase
  task automatic test_random_windows(input int phases, input int items);
    logic [AlphaW-1:0] long_val;
    logic [AlphaW-1:0] short_val;
    logic [PriceW-1:0] price;
    logic              restart;
    longint            level;
    longint            drift;
    int unsigned       span;
    int                remaining;
    for (int p = 0; p < phases; p++) begin
      case (phase_number % 6)
        0: begin
          long_val  = AlphaLongRst;
          short_val = AlphaShortRst;
        end
        1: begin
          long_val  = 17'h00000;
          short_val = 17'h1FFFF;
        end
        2: begin
          long_val  = 17'h1FFFF;
          short_val = 17'h00000;
        end
        3: begin
          long_val  = 17'h10000;
          short_val = 17'h10000;
        end
        4: begin
          long_val  = 17'($urandom_range(0, 4096));
          short_val = 17'($urandom_range(8192, 65536));
        end
        default: begin
          long_val  = 17'($urandom);
          short_val = 17'($urandom);
        end
      endcase
      phase_number++;
      write_alphas(long_val, short_val);
      remaining = 0;
      level = 0;
      drift = 0;
      span = 1;
      for (int i = 0; i < items; i++) begin
        restart = 1'b0;
        if (remaining == 0) begin
          // new window; one shorter than SeedLen is cut off by the next restart while seeding
          remaining = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6)
                                                 : $urandom_range(7, 90);
          restart = 1'b1;
          case ($urandom_range(0, 4))
            0: level = longint'($urandom);
            1: level = longint'($urandom_range(0, 255));
            2: level = 64'h0000_0000_FFFF_FFFF - longint'($urandom_range(0, 255));
            default: level = longint'($urandom_range(32'h0010_0000, 32'h7FFF_0000));
          endcase
          span  = 1 << $urandom_range(2, 30);
          drift = longint'(span / 4);
        end else begin
          // random walk with a trend that flips now and then, so crossovers happen
          if ($urandom_range(0, 7) == 0) drift = -drift;
          level = level + longint'($urandom_range(0, span)) - longint'(span / 2) + drift;
          if (level < 0) level = 0;
          if (level > 64'h0000_0000_FFFF_FFFF) level = 64'h0000_0000_FFFF_FFFF;
        end
        price = level[PriceW-1:0];
        if ($urandom_range(0, 24) == 0) price = $urandom;   // noise sample
        remaining--;
        if (!quiet && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 14));
        send_sample(price, restart);
      end
    end
  endtask

  // receiver side: random ready bursts, and the long hold-off on request
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // every result transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    ema_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction: long_average %h short_average %h",
               out_tdata[31:0], out_tdata[63:32]);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[31:0] !== want.long_avg) begin
          $error("long_average mismatch: expected %h, actual %h",
                 want.long_avg, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.short_avg) begin
          $error("short_average mismatch: expected %h, actual %h",
                 want.short_avg, out_tdata[63:32]);
          errors++;
        end
        if (out_tuser[0] !== want.seeded) begin
          $error("ready_res mismatch: expected %b, actual %b", want.seeded, out_tuser[0]);
          errors++;
        end
        if (out_tuser[2:1] !== want.crossover) begin
          $error("signal mismatch: expected %0d, actual %0d",
                 want.crossover, out_tuser[2:1]);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    // model matches the block's reset state
    alpha_l    = AlphaLongRst;
    alpha_s    = AlphaShortRst;
    avg_long   = '0;
    avg_short  = '0;
    seed_total = '0;
    seed_taken = '0;
    prev_rel   = REL_EQUAL;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_restart();
    test_price_extremes();
    test_crossovers();
    test_backpressure();
    test_random_windows(10, 140);
    // last stretch runs with no idling on either side
    wait_for_idle();
    quiet = 1'b1;
    test_random_windows(1, 150);
    wait_for_idle();

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
